// ===== rtl/miq_pkg.sv =====
// Package for the middle insert queue: widths, request and status codes,
// and the command/status structs passed between controller and datapath.
// No dependencies; every other file of the block uses it.
`default_nettype none

package miq_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_VALUE_WIDTH = 64;

  // Fixed port widths
  localparam int REQ_W    = 2;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_MID  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP       = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_POP_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // Value reported when nothing was popped
  localparam logic signed [DATA_W-1:0] NONE_VALUE = -64'sd1;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // first access: reads, pushes, pointer update
    logic finish;   // rebalancing write and result load
  } miq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } miq_sts_t;

endpackage

`default_nettype wire

// ===== rtl/miq_in_if.sv =====
// Request channel of the middle insert queue: valid/ready plus request payload.
// Depends on miq_pkg.
`default_nettype none

interface miq_in_if;
  logic                                valid;
  logic                                ready;
  logic [miq_pkg::REQ_W-1:0]           req_type;
  logic signed [miq_pkg::DATA_W-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/miq_out_if.sv =====
// Result channel of the middle insert queue: valid/ready plus result payload.
// Depends on miq_pkg.
`default_nettype none

interface miq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [miq_pkg::DATA_W-1:0]   popped_value;
  logic [miq_pkg::STATUS_W-1:0]        status;
  logic [miq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/miq_ctrl.sv =====
// Controller of the middle insert queue: sequences capture, access and finish
// of each item and drives the request ready. Depends on miq_pkg.
`default_nettype none

module miq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire miq_pkg::miq_sts_t sts,
  output miq_pkg::miq_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Decode state into commands; take a new item when idle or as one finishes
  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish  = 1'b1;
          req_ready   = 1'b1;
          cmd.capture = req_valid;
          state_next  = req_valid ? S_EXEC : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

// ===== rtl/miq_dp.sv =====
// Datapath of the middle insert queue: the two half rings (memories, heads,
// counts), the item register and the result register. Depends on miq_pkg.
`default_nettype none

module miq_dp #(
  parameter int CAPACITY    = miq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = miq_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire miq_pkg::miq_cmd_t                 cmd,
  output miq_pkg::miq_sts_t                      sts,
  input  wire logic [miq_pkg::REQ_W-1:0]         req_type,
  input  wire logic signed [miq_pkg::DATA_W-1:0] value,
  input  wire logic                              rsp_ready,
  output logic                                   rsp_valid,
  output logic signed [miq_pkg::DATA_W-1:0]      popped_value,
  output logic [miq_pkg::STATUS_W-1:0]           status,
  output logic [miq_pkg::OCC_W-1:0]              occupancy
);

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW   = $clog2(HALF + 1);
  localparam int TW   = CW + 1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // (base + off) mod HALF, with base below HALF and off at most HALF
  function automatic addr_t ring_add(input addr_t base, input cnt_t off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(HALF)) sum = sum - (CW+1)'(HALF);
    return AW'(sum);
  endfunction

  logic [VALUE_WIDTH-1:0] front_mem [0:HALF-1];
  logic [VALUE_WIDTH-1:0] back_mem  [0:HALF-1];

  addr_t fh, bh;
  cnt_t  fc, bc;
  logic [miq_pkg::REQ_W-1:0] req_q;
  logic [VALUE_WIDTH-1:0]    val_q;
  logic [VALUE_WIDTH-1:0]    front_rd, back_rd;

  logic                          mv_pend;
  addr_t                         mv_addr;
  logic                          res_pend;
  logic                          res_pop;
  logic [miq_pkg::STATUS_W-1:0]  res_status;
  logic [miq_pkg::OCC_W-1:0]     res_occ;

  // Access plan for the captured item
  logic [TW-1:0] total;
  logic          full, empty, balanced;
  addr_t         ftail, btail, fh_inc, bh_inc, bh_dec;
  addr_t         fh_next, bh_next;
  cnt_t          fc_next, bc_next;
  logic          f_push, b_push, mv_x, res_x, pop_x;
  addr_t         b_push_addr;
  logic [miq_pkg::STATUS_W-1:0] st_x;
  logic [miq_pkg::OCC_W-1:0]    occ_x;

  always_comb begin
    total    = TW'(fc) + TW'(bc);
    full     = total >= TW'(CAPACITY);
    empty    = total == '0;
    balanced = fc == bc;
    ftail    = ring_add(fh, fc);
    btail    = ring_add(bh, bc);
    fh_inc   = ring_add(fh, cnt_t'(1));
    bh_inc   = ring_add(bh, cnt_t'(1));
    bh_dec   = ring_add(bh, cnt_t'(HALF - 1));

    fh_next     = fh;
    bh_next     = bh;
    fc_next     = fc;
    bc_next     = bc;
    f_push      = 1'b0;
    b_push      = 1'b0;
    b_push_addr = btail;
    mv_x        = 1'b0;
    res_x       = 1'b0;
    pop_x       = 1'b0;
    st_x        = miq_pkg::ST_POP_OK;
    occ_x       = miq_pkg::OCC_W'(total);

    case (req_q)
      miq_pkg::REQ_PUSH_TAIL, miq_pkg::REQ_PUSH_MID: begin
        if (full) begin
          res_x = 1'b1;
          st_x  = miq_pkg::ST_PUSH_FULL;
        end else if (req_q == miq_pkg::REQ_PUSH_TAIL) begin
          if (balanced && bc == '0) begin
            // empty queue: the first entry lands in the front half
            f_push  = 1'b1;
            fc_next = fc + cnt_t'(1);
          end else if (balanced) begin
            // append to back, move back head over to the front tail
            b_push  = 1'b1;
            mv_x    = 1'b1;
            bh_next = bh_inc;
            fc_next = fc + cnt_t'(1);
          end else begin
            b_push  = 1'b1;
            bc_next = bc + cnt_t'(1);
          end
        end else begin
          if (!balanced) begin
            // front is one longer: new value becomes the back head
            b_push      = 1'b1;
            b_push_addr = bh_dec;
            bh_next     = bh_dec;
            bc_next     = bc + cnt_t'(1);
          end else begin
            f_push  = 1'b1;
            fc_next = fc + cnt_t'(1);
          end
        end
      end
      miq_pkg::REQ_POP: begin
        res_x = 1'b1;
        if (empty) begin
          st_x  = miq_pkg::ST_POP_EMPTY;
          occ_x = '0;
        end else begin
          pop_x   = 1'b1;
          occ_x   = miq_pkg::OCC_W'(total - TW'(1));
          fh_next = fh_inc;
          if (balanced) begin
            // refill the front tail from the back head
            mv_x    = 1'b1;
            bh_next = bh_inc;
            bc_next = bc - cnt_t'(1);
          end else begin
            fc_next = fc - cnt_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Front memory: push write during access, rebalancing write at finish
  logic                   f_we;
  addr_t                  f_wa;
  logic [VALUE_WIDTH-1:0] f_wd;

  always_comb begin
    f_we = (cmd.exec && f_push) || (cmd.finish && mv_pend);
    f_wa = cmd.finish ? mv_addr : ftail;
    f_wd = cmd.finish ? back_rd : val_q;
  end

  always_ff @(posedge clk) begin
    if (f_we) front_mem[f_wa] <= f_wd;
    if (cmd.exec) front_rd <= front_mem[fh];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && b_push) back_mem[b_push_addr] <= val_q;
    if (cmd.exec) back_rd <= back_mem[bh];
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      val_q <= value[VALUE_WIDTH-1:0];
    end
  end

  // Ring pointers, counts and the pending finish work
  always_ff @(posedge clk) begin
    if (rst) begin
      fh       <= '0;
      bh       <= '0;
      fc       <= '0;
      bc       <= '0;
      mv_pend  <= 1'b0;
      res_pend <= 1'b0;
    end else if (cmd.exec) begin
      fh       <= fh_next;
      bh       <= bh_next;
      fc       <= fc_next;
      bc       <= bc_next;
      mv_pend  <= mv_x;
      res_pend <= res_x;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mv_addr    <= ftail;
      res_pop    <= pop_x;
      res_status <= st_x;
      res_occ    <= occ_x;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish && res_pend) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && res_pend) begin
      popped_value <= res_pop ? miq_pkg::DATA_W'($signed(front_rd)) : miq_pkg::NONE_VALUE;
      status       <= res_status;
      occupancy    <= res_occ;
    end
  end

  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// ===== rtl/middle_insert_queue_unit.sv =====
// Middle insert queue: a FIFO of signed values that also takes pushes at its
// middle, held as two ring-buffer halves in block memories that are rebalanced
// after every item. Each item is captured, then makes one memory access, and then
// the registered read feeds the rebalancing write and the result. A new item is
// taken only while idle or as the last one finishes; a result still waiting in
// the output register stalls that finish step. Pushes that succeed give no
// result. The memories need no clearing pass after reset.
// Depends on miq_pkg, miq_in_if, miq_out_if, miq_ctrl and miq_dp.
`default_nettype none

module middle_insert_queue_unit #(
  parameter int CAPACITY    = miq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = miq_pkg::DEF_VALUE_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst,
  miq_in_if.sink    req,
  miq_out_if.source rsp
);

  miq_pkg::miq_cmd_t cmd;
  miq_pkg::miq_sts_t sts;

  miq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  miq_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req.req_type),
    .value        (req.value),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .popped_value (rsp.popped_value),
    .status       (rsp.status),
    .occupancy    (rsp.occupancy)
  );

endmodule

`default_nettype wire

// ===== rtl/miq_checker.sv =====
// Port-level checks for the middle insert queue, bound to the top level.
// Depends on miq_pkg and middle_insert_queue_unit.
`default_nettype none

module miq_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              req_valid,
  input wire logic                              req_ready,
  input wire logic                              rsp_valid,
  input wire logic                              rsp_ready,
  input wire logic signed [miq_pkg::DATA_W-1:0] popped_value,
  input wire logic [miq_pkg::STATUS_W-1:0]      status,
  input wire logic [miq_pkg::OCC_W-1:0]         occupancy
);

  // An empty pop reports the none value and an empty queue
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == miq_pkg::ST_POP_EMPTY) |->
      (popped_value == miq_pkg::NONE_VALUE && occupancy == '0))
    else $error("empty pop result malformed");

  // A dropped push reports the none value
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == miq_pkg::ST_PUSH_FULL) |-> popped_value == miq_pkg::NONE_VALUE)
    else $error("dropped push result malformed");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == miq_pkg::ST_POP_OK || status == miq_pkg::ST_POP_EMPTY ||
                   status == miq_pkg::ST_PUSH_FULL))
    else $error("undefined status code");

  // An accepted item occupies the block for its access cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item taken during access cycle");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(popped_value) && $stable(status) && $stable(occupancy)))
    else $error("stalled result changed");

endmodule

bind middle_insert_queue_unit miq_checker u_miq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .popped_value (rsp.popped_value),
  .status       (rsp.status),
  .occupancy    (rsp.occupancy)
);

`default_nettype wire

// ===== tb/middle_insert_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for middle_insert_queue_unit: a shadow queue predicts
// every result, random stalls on both channels. Needs miq_pkg and both interfaces.

module middle_insert_queue_unit_tb;

  localparam int QUEUE_DEPTH = miq_pkg::DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 500_000;
  localparam logic signed [miq_pkg::DATA_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [miq_pkg::DATA_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [miq_pkg::DATA_W-1:0] popped_value;
    logic [miq_pkg::STATUS_W-1:0]      status;
    logic [miq_pkg::OCC_W-1:0]         occupancy;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  miq_in_if  req_ch ();
  miq_out_if rsp_ch ();

  middle_insert_queue_unit #(
    .CAPACITY    (QUEUE_DEPTH),
    .VALUE_WIDTH (miq_pkg::DEF_VALUE_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow of the queue contents, head at index 0
  logic signed [miq_pkg::DATA_W-1:0] shadow_q[$];
  queue_result_t                     pending_results[$];

  int fail_count   = 0;
  int cycle_count  = 0;
  int items_sent   = 0;
  int pops_ok      = 0;
  int pops_empty   = 0;
  int pushes_full  = 0;
  int mid_pushes   = 0;
  int peak_fill    = 0;
  int tx_calm      = 0;
  int rx_calm      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle cycles before the next item; occasionally run a stretch with none
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [miq_pkg::REQ_W-1:0] pick_op(int pop_pct, int unused_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < unused_pct) return miq_pkg::REQ_UNUSED;
    if (roll < unused_pct + pop_pct) return miq_pkg::REQ_POP;
    return ($urandom_range(0, 1) != 0) ? miq_pkg::REQ_PUSH_MID : miq_pkg::REQ_PUSH_TAIL;
  endfunction

  function automatic logic signed [miq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -64'sd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Advance the shadow queue by one accepted item and queue its result, if any
  function automatic void shadow_apply(logic [miq_pkg::REQ_W-1:0] op,
                                       logic signed [miq_pkg::DATA_W-1:0] v);
    queue_result_t res;
    case (op)
      miq_pkg::REQ_PUSH_TAIL, miq_pkg::REQ_PUSH_MID: begin
        if (shadow_q.size() >= QUEUE_DEPTH) begin
          res.popped_value = miq_pkg::NONE_VALUE;
          res.status       = miq_pkg::ST_PUSH_FULL;
          res.occupancy    = miq_pkg::OCC_W'(shadow_q.size());
          pending_results.push_back(res);
          pushes_full++;
        end else if (op == miq_pkg::REQ_PUSH_TAIL) begin
          shadow_q.push_back(v);
        end else begin
          // middle sits after the older ceil(n/2) entries
          shadow_q.insert((shadow_q.size() + 1) / 2, v);
          mid_pushes++;
        end
      end
      miq_pkg::REQ_POP: begin
        if (shadow_q.size() == 0) begin
          res.popped_value = miq_pkg::NONE_VALUE;
          res.status       = miq_pkg::ST_POP_EMPTY;
          res.occupancy    = '0;
          pops_empty++;
        end else begin
          res.popped_value = shadow_q.pop_front();
          res.status       = miq_pkg::ST_POP_OK;
          res.occupancy    = miq_pkg::OCC_W'(shadow_q.size());
          pops_ok++;
        end
        pending_results.push_back(res);
      end
      default: ;  // unused code: dropped silently
    endcase
    if (shadow_q.size() > peak_fill) peak_fill = shadow_q.size();
  endfunction

  // Offer one item, hold it until accepted, then predict
  task automatic send_item(logic [miq_pkg::REQ_W-1:0] op,
                           logic signed [miq_pkg::DATA_W-1:0] v);
    int gap;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    shadow_apply(op, v);
  endtask

  // Stop offering and hold until every predicted result has arrived
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(miq_pkg::REQ_POP, VAL_MAX);             // pop on empty queue
    send_item(miq_pkg::REQ_PUSH_TAIL, VAL_MAX);
    send_item(miq_pkg::REQ_PUSH_MID, VAL_MIN);        // front half longer: lands at back head
    send_item(miq_pkg::REQ_PUSH_MID, '0);             // halves equal: appends to front half
    send_item(miq_pkg::REQ_PUSH_TAIL, -64'sd1);
    send_item(miq_pkg::REQ_PUSH_MID, 64'sh5555_5555_5555_5555);
    send_item(miq_pkg::REQ_PUSH_MID, 64'shAAAA_AAAA_AAAA_AAAA);
    send_item(miq_pkg::REQ_UNUSED, 64'sh0000_0000_0000_0001);  // ignored
    send_item(miq_pkg::REQ_PUSH_TAIL, 64'sh0000_0000_0000_0001);
    repeat (8) send_item(miq_pkg::REQ_POP, '0);      // drain, last one on empty
    wait_results_drained();
  endtask

  // Short queue, balanced mix: frequent empty pops
  task automatic test_random_mix();
    repeat (100) send_item(pick_op(40, 4), pick_value());
    wait_results_drained();
  endtask

  // Push-heavy until full, then hover at capacity so pushes get dropped
  task automatic test_fill_to_capacity();
    while (shadow_q.size() < QUEUE_DEPTH) send_item(pick_op(3, 1), pick_value());
    repeat (40) send_item(pick_op(30, 2), pick_value());
    wait_results_drained();
  endtask

  // Pop-heavy stretch taken off the nearly full queue
  task automatic test_drain();
    repeat (60) send_item(pick_op(88, 2), pick_value());
  endtask

  // Result side: random back-pressure, compare each item with the oldest prediction
  initial begin
    int stall;
    queue_result_t want;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_wait(rx_calm);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: popped_value %0d status %0d occupancy %0d",
               rsp_ch.popped_value, rsp_ch.status, rsp_ch.occupancy);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, got %0d", want.popped_value,
                 rsp_ch.popped_value);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Reset, run each test in turn, then settle and report
  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= miq_pkg::REQ_PUSH_TAIL;
    req_ch.value    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_fill_to_capacity();
    test_drain();

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end

    $display("Covered %0d items: %0d pops, %0d pops on empty, %0d dropped pushes,",
             items_sent, pops_ok, pops_empty, pushes_full);
    $display("%0d middle pushes, fill peaked at %0d of %0d entries.",
             mid_pushes, peak_fill, QUEUE_DEPTH);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/miq_pkg.sv
rtl/miq_in_if.sv
rtl/miq_out_if.sv
rtl/miq_ctrl.sv
rtl/miq_dp.sv
rtl/middle_insert_queue_unit.sv
rtl/miq_checker.sv
tb/middle_insert_queue_unit_tb.sv
